[rtl/scc_pkg.sv]
`default_nettype none

package scc_pkg;

    // access kinds
    localparam logic [2:0] ACC_REG_READ  = 3'd0;
    localparam logic [2:0] ACC_REG_WRITE = 3'd1;
    localparam logic [2:0] ACC_DMA_LOW   = 3'd2;
    localparam logic [2:0] ACC_DMA_HIGH  = 3'd3;
    localparam logic [2:0] ACC_BUS_RESET = 3'd4;

    // register map
    localparam int          NUM_REGS   = 32;
    localparam logic [4:0] REG_CDB0   = 5'h03;
    localparam logic [4:0] REG_TARGET = 5'h15;
    localparam logic [4:0] REG_STATUS = 5'h17;
    localparam logic [4:0] REG_CMD    = 5'h18;
    localparam logic [4:0] REG_AUX    = 5'h1f;

    localparam logic [7:0] AUX_IRQ = 8'h80;

    // controller commands
    localparam logic [7:0] CMD_RESET  = 8'h00;
    localparam logic [7:0] CMD_SELECT = 8'h08;

    // status codes
    localparam logic [7:0] STS_RESET_DONE = 8'h01;
    localparam logic [7:0] STS_GOOD       = 8'h16;
    localparam logic [7:0] STS_FAIL       = 8'h42;
    localparam logic [7:0] STS_BUS_RESET  = 8'h00;

    // cdb opcodes
    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_READ_6          = 8'h08;
    localparam logic [7:0] OP_WRITE_6         = 8'h0a;
    localparam logic [7:0] OP_SEEK_6          = 8'h0b;
    localparam logic [7:0] OP_VENDOR_0D       = 8'h0d;
    localparam logic [7:0] OP_MODE_SENSE      = 8'h1a;
    localparam logic [7:0] OP_READ_10         = 8'h28;

    localparam logic [7:0] PAGE_3 = 8'h03;
    localparam logic [7:0] PAGE_4 = 8'h04;

    // transfer kinds
    localparam logic [2:0] XK_NONE     = 3'd0;
    localparam logic [2:0] XK_TO_MEM   = 3'd1;
    localparam logic [2:0] XK_FROM_MEM = 3'd2;
    localparam logic [2:0] XK_PAGE_3   = 3'd3;
    localparam logic [2:0] XK_PAGE_4   = 3'd4;

    localparam int XFER_ADDR_BITS = 19;
    localparam int CDB_BYTES      = 6;

    typedef logic [CDB_BYTES-1:0][7:0] t_cdb;

    typedef struct packed {
        logic [7:0]                status;
        logic [2:0]                kind;
        logic [31:0]               lba;
        logic [7:0]                sectors;
        logic [XFER_ADDR_BITS-1:0] addr;
    } t_xfer;

endpackage

`default_nettype wire

[rtl/scc_if.sv]
`default_nettype none

interface scc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] access_kind;
    logic [4:0] reg_index;
    logic [15:0] write_data;

    modport source(output valid, output access_kind, output reg_index,
                   output write_data, input ready);
    modport sink(input valid, input access_kind, input reg_index,
                 input write_data, output ready);
endinterface

interface scc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        irq_level;
    logic [2:0]  xfer_kind;
    logic [31:0] xfer_lba;
    logic [7:0]  xfer_sectors;
    logic [18:0] xfer_address;
    logic        cmd_error;

    modport source(output valid, output read_data, output irq_level,
                   output xfer_kind, output xfer_lba, output xfer_sectors,
                   output xfer_address, output cmd_error, input ready);
    modport sink(input valid, input read_data, input irq_level,
                 input xfer_kind, input xfer_lba, input xfer_sectors,
                 input xfer_address, input cmd_error, output ready);
endinterface

`default_nettype wire

[rtl/scc_cmd_decode.sv]
`default_nettype none

module scc_cmd_decode (
    input  var scc_pkg::t_cdb  i_cdb,
    input  var logic [7:0]     i_target,
    input  var logic [7:0]     i_present,
    input  var logic [scc_pkg::XFER_ADDR_BITS-1:0] i_dma_addr,
    output scc_pkg::t_xfer     o_xfer
);
    import scc_pkg::*;

    logic [2:0] target_id;

    assign target_id = i_target[2:0];

    always_comb begin
        o_xfer         = '0;
        o_xfer.status  = STS_GOOD;
        o_xfer.kind    = XK_NONE;
        if (!i_present[target_id]) begin
            o_xfer.status = STS_FAIL;
        end else begin
            unique case (i_cdb[0]) inside
                OP_TEST_UNIT_READY, OP_SEEK_6, OP_VENDOR_0D: begin
                end
                OP_READ_6, OP_WRITE_6: begin
                    o_xfer.kind    = (i_cdb[0] == OP_READ_6) ? XK_TO_MEM : XK_FROM_MEM;
                    // 21-bit block address
                    o_xfer.lba     = {11'd0, i_cdb[1][4:0], i_cdb[2], i_cdb[3]};
                    o_xfer.sectors = i_cdb[4];
                    o_xfer.addr    = i_dma_addr;
                end
                OP_READ_10: begin
                    // length bytes ignored, always one sector
                    o_xfer.kind    = XK_TO_MEM;
                    o_xfer.lba     = {i_cdb[2], i_cdb[3], i_cdb[4], i_cdb[5]};
                    o_xfer.sectors = 8'd1;
                    o_xfer.addr    = i_dma_addr;
                end
                OP_MODE_SENSE: begin
                    if (i_cdb[2] == PAGE_3 || i_cdb[2] == PAGE_4) begin
                        o_xfer.kind = (i_cdb[2] == PAGE_3) ? XK_PAGE_3 : XK_PAGE_4;
                        o_xfer.addr = i_dma_addr;
                    end
                end
                default: begin
                    o_xfer.status = STS_FAIL;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/scsi_controller_command_registers_unit.sv]
`default_nettype none

// scsi controller register unit: one bus access is taken per transfer on i_req and
// answered by exactly one result transfer on o_rsp. an access is decoded and applied
// to the 32-byte register file, the dma start address and the interrupt line in the
// cycle it is accepted; its result is registered in an output register, so
// the unit sustains one access per clock and keeps accepting while a result is held
// as long as o_rsp.ready drains it. writing the command register with 0 or 8 runs the
// command (8 selects the target in register 0x15 and decodes the cdb held from
// register 0x03) and raises the interrupt; reading the status register 0x17 clears
// the aux interrupt bit and lowers it. present_targets resets to 3 and must be written
// through i_cfg_we / i_cfg_data only while the unit is idle; the unit does not check.
module scsi_controller_command_registers_unit #(
    parameter int DMA_ADDRESS_BITS = 19
) (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       i_cfg_we,
    input  var logic [7:0] i_cfg_data,
    scc_req_if.sink        i_req,
    scc_rsp_if.source      o_rsp
);
    import scc_pkg::*;

    // architectural state
    logic [7:0]                  r_regs [NUM_REGS];
    logic [7:0]                  n_regs [NUM_REGS];
    logic [DMA_ADDRESS_BITS-1:0] r_dma;
    logic [DMA_ADDRESS_BITS-1:0] n_dma;
    logic                        r_irq;
    logic                        n_irq;
    logic [7:0]                  r_present;

    // result register
    logic                      r_out_valid;
    logic [7:0]                r_read_data;
    logic                      r_irq_level;
    logic [2:0]                r_xfer_kind;
    logic [31:0]               r_xfer_lba;
    logic [7:0]                r_xfer_sectors;
    logic [XFER_ADDR_BITS-1:0] r_xfer_address;
    logic                      r_cmd_error;

    logic                      n_read_data_en;
    logic [7:0]                n_read_data;
    logic                      n_cmd_error;
    t_xfer                     n_xfer;

    logic       accept;
    logic [31:0] dma_ext;
    t_cdb       cdb;
    t_xfer      dec_xfer;

    // take a new access whenever the result slot is empty or being drained
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign dma_ext = 32'(r_dma);

    always_comb begin
        for (int b = 0; b < CDB_BYTES; b++) begin
            cdb[b] = r_regs[REG_CDB0 + 5'(b)];
        end
    end

    scc_cmd_decode u_decode (
        .i_cdb      (cdb),
        .i_target   (r_regs[REG_TARGET]),
        .i_present  (r_present),
        .i_dma_addr (XFER_ADDR_BITS'(dma_ext)),
        .o_xfer     (dec_xfer)
    );

    // next state and result for the access on the request channel
    always_comb begin
        n_regs         = r_regs;
        n_dma          = r_dma;
        n_irq          = r_irq;
        n_read_data_en = 1'b0;
        n_read_data    = 8'd0;
        n_cmd_error    = 1'b0;
        n_xfer         = '0;
        unique case (i_req.access_kind)
            ACC_REG_READ: begin
                n_read_data_en = 1'b1;
                n_read_data    = r_regs[i_req.reg_index];
                if (i_req.reg_index == REG_STATUS) begin
                    n_regs[REG_AUX] = r_regs[REG_AUX] & ~AUX_IRQ;
                    n_irq           = 1'b0;
                end
            end
            ACC_REG_WRITE: begin
                // upper byte of the data is ignored
                n_regs[i_req.reg_index] = i_req.write_data[7:0];
                if (i_req.reg_index == REG_CMD) begin
                    if (i_req.write_data[7:0] == CMD_RESET) begin
                        n_regs[REG_STATUS] = STS_RESET_DONE;
                        n_regs[REG_AUX]    = r_regs[REG_AUX] | AUX_IRQ;
                        n_irq              = 1'b1;
                    end else if (i_req.write_data[7:0] == CMD_SELECT) begin
                        n_regs[REG_STATUS] = dec_xfer.status;
                        n_regs[REG_AUX]    = r_regs[REG_AUX] | AUX_IRQ;
                        n_irq              = 1'b1;
                        n_xfer             = dec_xfer;
                    end else begin
                        // unsupported command: byte kept, nothing else moves
                        n_cmd_error = 1'b1;
                    end
                end
            end
            ACC_DMA_LOW: begin
                n_dma = DMA_ADDRESS_BITS'({dma_ext[31:16], i_req.write_data});
            end
            ACC_DMA_HIGH: begin
                n_dma = DMA_ADDRESS_BITS'({i_req.write_data, dma_ext[15:0]});
            end
            ACC_BUS_RESET: begin
                n_regs[REG_STATUS] = STS_BUS_RESET;
                n_regs[REG_AUX]    = r_regs[REG_AUX] | AUX_IRQ;
                n_irq              = 1'b1;
            end
            default: begin
                // unused access kinds leave everything alone
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_dma       <= '0;
            r_irq       <= 1'b0;
            r_present   <= 8'd3;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_present <= i_cfg_data;
            end
            if (accept) begin
                r_regs      <= n_regs;
                r_dma       <= n_dma;
                r_irq       <= n_irq;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data    <= n_read_data_en ? n_read_data : 8'd0;
            r_irq_level    <= n_irq;
            r_xfer_kind    <= n_xfer.kind;
            r_xfer_lba     <= n_xfer.lba;
            r_xfer_sectors <= n_xfer.sectors;
            r_xfer_address <= n_xfer.addr;
            r_cmd_error    <= n_cmd_error;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_read_data;
    assign o_rsp.irq_level    = r_irq_level;
    assign o_rsp.xfer_kind    = r_xfer_kind;
    assign o_rsp.xfer_lba     = r_xfer_lba;
    assign o_rsp.xfer_sectors = r_xfer_sectors;
    assign o_rsp.xfer_address = r_xfer_address;
    assign o_rsp.cmd_error    = r_cmd_error;

endmodule

`default_nettype wire
